>>> rtl/lps_pkg.sv
// Shared constants for the line pixel stepper.
package lps_pkg;

    // Default coordinate width and the supported range.
    localparam int COORD_BITS_DEF = 11;

    // Color register width.
    localparam int RGB_BITS = 16;

    // APB data and address widths.
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 3;

    // Register index taken from the word address.
    localparam int CFG_INDEX_BITS = CFG_ADDR_BITS - 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_COLOR = '0;

    // Command codes carried in the input beat.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

endpackage

>>> rtl/lps_ifs.sv
// Valid/ready channel interfaces for the line pixel stepper.
interface lps_in_if #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (output valid, output cmd, output x_start, output y_start,
                    output x_end, output y_end, input ready);
    modport sink   (input valid, input cmd, input x_start, input y_start,
                    input x_end, input y_end, output ready);
endinterface

interface lps_out_if #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [COORD_BITS-1:0]       pixel_x;
    logic [COORD_BITS-1:0]       pixel_y;
    logic [lps_pkg::RGB_BITS-1:0] pixel_rgb;
    logic                        last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_rgb,
                    output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input pixel_rgb,
                    input last_pixel, output ready);
endinterface

>>> rtl/line_pixel_stepper.sv
// Bresenham line walker: one pixel beat out for each start or busy step beat in.
// Each pixel is registered in the output register, or in the skid register, which
// holds one extra pixel while the output is stalled. One input beat per cycle is
// taken while the skid register is empty; the single walk update is combinational
// between the line state registers and the output and skid registers.
// Reset (rst_n, asynchronous, active low) makes the walker idle, empties the output
// and skid registers and clears the color register.
module line_pixel_stepper #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lps_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [lps_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [lps_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                              pready,
    lps_in_if.sink                            in_ch,
    lps_out_if.source                         out_ch
);
    import lps_pkg::*;

    // The error term needs two bits above the coordinate width: one for the
    // sign and one for the headroom of an add before the correction.
    localparam int ERR_BITS = COORD_BITS + 2;

    // Configuration register.
    logic [RGB_BITS-1:0]       color_reg;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;

    // Line state.
    logic                  busy_reg, busy_next;
    logic                  y_major_reg, y_major_next;
    logic                  col_dec_reg, col_dec_next;
    logic                  row_dec_reg, row_dec_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [COORD_BITS-1:0] end_col_reg, end_col_next;
    logic [COORD_BITS-1:0] end_row_reg, end_row_next;
    logic [COORD_BITS-1:0] dx_reg, dx_next;
    logic [COORD_BITS-1:0] dy_reg, dy_next;
    logic [ERR_BITS-1:0]   err_reg, err_next;

    // Output register and skid register.
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic [RGB_BITS-1:0]   out_rgb_reg;
    logic                  out_last_reg;
    logic                  skid_valid_reg;
    logic [COORD_BITS-1:0] skid_x_reg;
    logic [COORD_BITS-1:0] skid_y_reg;
    logic [RGB_BITS-1:0]   skid_rgb_reg;
    logic                  skid_last_reg;

    // Handshake terms.
    logic in_fire;
    logic out_fire;
    logic out_stalled;

    // Start decode.
    logic                  x_up;
    logic                  y_up;
    logic [COORD_BITS-1:0] abs_dx;
    logic [COORD_BITS-1:0] abs_dy;
    logic                  start_y_major;
    logic [COORD_BITS-1:0] start_major;
    logic [ERR_BITS-1:0]   start_err;
    logic                  start_last;

    // Step decode.
    logic [COORD_BITS-1:0] col_step;
    logic [COORD_BITS-1:0] row_step;
    logic [COORD_BITS-1:0] d_minor;
    logic [COORD_BITS-1:0] d_major;
    logic [ERR_BITS-1:0]   err_add;
    logic                  minor_move;
    logic [COORD_BITS-1:0] step_col;
    logic [COORD_BITS-1:0] step_row;
    logic                  step_last;

    // Result of the beat being accepted.
    logic                  res_valid;
    logic                  res_last;

    // ------------------------------------------------------------------
    // APB register port. Writes complete in the access phase; there are
    // no wait states. Addresses beyond the color register read as zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_index = paddr[CFG_ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (cfg_index == REG_PIXEL_COLOR)
        begin
            prdata = CFG_DATA_BITS'(color_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= '0;
        end
        else if (cfg_write && (cfg_index == REG_PIXEL_COLOR))
        begin
            color_reg <= pwdata[RGB_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The input is blocked only when the skid register holds a
    // pixel, which it takes only while the output register is stalled.
    // ------------------------------------------------------------------
    assign in_ch.ready = !skid_valid_reg;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_fire    = out_valid_reg && out_ch.ready;
    assign out_stalled = out_valid_reg && !out_ch.ready;

    // ------------------------------------------------------------------
    // Start beat: absolute deltas, step directions and the major axis.
    // A coordinate moves downward when its end is not above its start,
    // which only matters when its delta is nonzero.
    // ------------------------------------------------------------------
    assign x_up          = in_ch.x_end > in_ch.x_start;
    assign y_up          = in_ch.y_end > in_ch.y_start;
    assign abs_dx        = x_up ? (in_ch.x_end - in_ch.x_start) : (in_ch.x_start - in_ch.x_end);
    assign abs_dy        = y_up ? (in_ch.y_end - in_ch.y_start) : (in_ch.y_start - in_ch.y_end);
    assign start_y_major = abs_dx < abs_dy;
    assign start_major   = start_y_major ? abs_dy : abs_dx;
    // The error is seeded with minus half the major delta.
    assign start_err     = ERR_BITS'(0) - ERR_BITS'(start_major >> 1);
    // A start emits the first endpoint; it is also the last one when the
    // major coordinate already sits on the end.
    assign start_last    = start_y_major ? (in_ch.y_start == in_ch.y_end)
                                         : (in_ch.x_start == in_ch.x_end);

    // ------------------------------------------------------------------
    // Step beat: the major coordinate always moves one unit. The error
    // gains the minor delta, and once it is not negative the minor
    // coordinate moves and the error gives back the major delta. A zero
    // minor delta never moves the minor coordinate, so straight runs stay
    // on their row or column.
    // ------------------------------------------------------------------
    assign col_step   = col_dec_reg ? (col_reg - COORD_BITS'(1)) : (col_reg + COORD_BITS'(1));
    assign row_step   = row_dec_reg ? (row_reg - COORD_BITS'(1)) : (row_reg + COORD_BITS'(1));
    assign d_minor    = y_major_reg ? dx_reg : dy_reg;
    assign d_major    = y_major_reg ? dy_reg : dx_reg;
    assign err_add    = err_reg + ERR_BITS'(d_minor);
    assign minor_move = !err_add[ERR_BITS-1] && (d_minor != '0);
    assign step_col   = (y_major_reg && !minor_move) ? col_reg : col_step;
    assign step_row   = (!y_major_reg && !minor_move) ? row_reg : row_step;
    assign step_last  = y_major_reg ? (step_row == end_row_reg) : (step_col == end_col_reg);

    // ------------------------------------------------------------------
    // Next line state. A start always restarts the walk, busy or not; a
    // step while idle changes nothing and gives no pixel.
    // ------------------------------------------------------------------
    always_comb
    begin
        busy_next    = busy_reg;
        y_major_next = y_major_reg;
        col_dec_next = col_dec_reg;
        row_dec_next = row_dec_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        end_col_next = end_col_reg;
        end_row_next = end_row_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        err_next     = err_reg;
        res_valid    = 1'b0;
        res_last     = 1'b0;

        if (in_fire)
        begin
            unique case (in_ch.cmd)
                CMD_START:
                begin
                    y_major_next = start_y_major;
                    col_dec_next = !x_up;
                    row_dec_next = !y_up;
                    col_next     = in_ch.x_start;
                    row_next     = in_ch.y_start;
                    end_col_next = in_ch.x_end;
                    end_row_next = in_ch.y_end;
                    dx_next      = abs_dx;
                    dy_next      = abs_dy;
                    err_next     = start_err;
                    busy_next    = !start_last;
                    res_valid    = 1'b1;
                    res_last     = start_last;
                end
                CMD_STEP:
                begin
                    if (busy_reg)
                    begin
                        col_next  = step_col;
                        row_next  = step_row;
                        err_next  = minor_move ? (err_add - ERR_BITS'(d_major)) : err_add;
                        busy_next = !step_last;
                        res_valid = 1'b1;
                        res_last  = step_last;
                    end
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // Walk registers only matter while busy, and a start loads them all.
    always_ff @(posedge clk)
    begin
        y_major_reg <= y_major_next;
        col_dec_reg <= col_dec_next;
        row_dec_reg <= row_dec_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        end_col_reg <= end_col_next;
        end_row_reg <= end_row_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        err_reg     <= err_next;
    end

    // ------------------------------------------------------------------
    // Output register with a skid register behind it. A new pixel goes to
    // the output register when that is free or draining this cycle, and to
    // the skid register when the output is stalled. The pixel carries the
    // color as it stands when the pixel is made. The current pixel of the
    // walk is col_next and row_next.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_stalled)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_x_reg    <= skid_x_reg;
                out_y_reg    <= skid_y_reg;
                out_rgb_reg  <= skid_rgb_reg;
                out_last_reg <= skid_last_reg;
            end
        end
        else if (res_valid)
        begin
            if (out_stalled)
            begin
                skid_x_reg    <= col_next;
                skid_y_reg    <= row_next;
                skid_rgb_reg  <= color_reg;
                skid_last_reg <= res_last;
            end
            else
            begin
                out_x_reg    <= col_next;
                out_y_reg    <= row_next;
                out_rgb_reg  <= color_reg;
                out_last_reg <= res_last;
            end
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pixel_x    = out_x_reg;
    assign out_ch.pixel_y    = out_y_reg;
    assign out_ch.pixel_rgb  = out_rgb_reg;
    assign out_ch.last_pixel = out_last_reg;

endmodule

>>> rtl/lps_checker.sv
// Port-level assertions for the line pixel stepper and their bind.
module lps_checker #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         in_cmd,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [COORD_BITS-1:0]        pixel_x,
    input logic [COORD_BITS-1:0]        pixel_y,
    input logic [lps_pkg::RGB_BITS-1:0] pixel_rgb,
    input logic                         last_pixel
);
    import lps_pkg::*;

    // A stalled output beat stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    // A stalled output beat keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_x) && $stable(pixel_y)
                                    && $stable(pixel_rgb) && $stable(last_pixel))
        else $error("output payload changed while stalled");

    // The input is only ever held off while a pixel waits on the output.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input blocked with an empty output");

    // A start always gives a pixel, shown in the next cycle when the
    // output register is free or draining.
    a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_cmd == CMD_START) && (!out_valid || out_ready)
        |=> out_valid)
        else $error("start beat gave no pixel");

endmodule

bind line_pixel_stepper lps_checker #(
    .COORD_BITS(COORD_BITS)
) u_lps_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_cmd     (in_ch.cmd),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .pixel_x    (out_ch.pixel_x),
    .pixel_y    (out_ch.pixel_y),
    .pixel_rgb  (out_ch.pixel_rgb),
    .last_pixel (out_ch.last_pixel)
);

>>> bench/line_pixel_stepper_tb.sv
// Self-checking testbench for the line pixel stepper: directed and random line walks.
`timescale 1ns / 100ps

module line_pixel_stepper_tb;
    import lps_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam logic [CW-1:0] COORD_MAX = '1;

    // One beat on the command channel and one beat on the pixel channel.
    typedef struct packed {
        logic          cmd;
        logic [CW-1:0] x_start;
        logic [CW-1:0] y_start;
        logic [CW-1:0] x_end;
        logic [CW-1:0] y_end;
    } line_cmd_t;

    typedef struct packed {
        logic [CW-1:0]       x;
        logic [CW-1:0]       y;
        logic [RGB_BITS-1:0] rgb;
        logic                last;
    } pixel_t;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [CFG_ADDR_BITS-1:0]  paddr;
    logic [CFG_DATA_BITS-1:0]  pwdata;
    logic [CFG_DATA_BITS-1:0]  prdata;
    logic                      pready;

    lps_in_if  #(.COORD_BITS(CW)) in_ch ();
    lps_out_if #(.COORD_BITS(CW)) out_ch ();

    line_pixel_stepper #(.COORD_BITS(CW)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Command beats waiting to be driven, and pixels the walker should produce.
    line_cmd_t cmd_backlog[$];
    pixel_t    pixel_expect_q[$];

    // Walker mirror: current pixel, error term, deltas and directions of the line.
    logic [CW-1:0]       walk_col;
    logic [CW-1:0]       walk_row;
    logic [CW-1:0]       goal_col;
    logic [CW-1:0]       goal_row;
    logic [CW-1:0]       span_x;
    logic [CW-1:0]       span_y;
    int                  walk_err;
    bit                  col_down;
    bit                  row_down;
    bit                  steep;
    bit                  walking;
    logic [RGB_BITS-1:0] color_reg;

    // Idle and stall rates in percent, changed from phase to phase.
    int        src_idle_pct;
    int        sink_stall_pct;
    bit        in_taken;
    line_cmd_t next_cmd;

    int fail_count;
    int beats_in;
    int starts_in;
    int pixels_out;
    int colors_used;
    int useful_beats;

    // Free-running clock, 8 ns period.
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Generous run limit; a healthy run finishes far earlier.
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Advances the walker mirror by one command beat. Returns 1 when the beat
    // produces a pixel, which is then handed back in px.
    function automatic bit walk_one(input line_cmd_t b, output pixel_t px);
        bit at_end;
        px = '0;
        if (b.cmd == CMD_START)
        begin
            // A start always wins, even in the middle of a line.
            col_down = !(b.x_end > b.x_start);
            row_down = !(b.y_end > b.y_start);
            span_x   = col_down ? b.x_start - b.x_end : b.x_end - b.x_start;
            span_y   = row_down ? b.y_start - b.y_end : b.y_end - b.y_start;
            steep    = span_x < span_y;
            walk_err = -int'((steep ? span_y : span_x) >> 1);
            walk_col = b.x_start;
            walk_row = b.y_start;
            goal_col = b.x_end;
            goal_row = b.y_end;
            at_end   = steep ? (walk_row == goal_row) : (walk_col == goal_col);
        end
        else
        begin
            // A step with no line in progress is simply dropped.
            if (!walking)
                return 1'b0;
            if (steep)
            begin
                walk_row = row_down ? walk_row - 1'b1 : walk_row + 1'b1;
                walk_err += int'(span_x);
                // With no minor delta the column never moves, even at zero error.
                if (walk_err >= 0 && span_x != 0)
                begin
                    walk_col = col_down ? walk_col - 1'b1 : walk_col + 1'b1;
                    walk_err -= int'(span_y);
                end
                at_end = (walk_row == goal_row);
            end
            else
            begin
                walk_col = col_down ? walk_col - 1'b1 : walk_col + 1'b1;
                walk_err += int'(span_y);
                if (walk_err >= 0 && span_y != 0)
                begin
                    walk_row = row_down ? walk_row - 1'b1 : walk_row + 1'b1;
                    walk_err -= int'(span_x);
                end
                at_end = (walk_col == goal_col);
            end
        end
        walking = !at_end;
        px = '{x: walk_col, y: walk_row, rgb: color_reg, last: at_end};
        return 1'b1;
    endfunction

    // Command driver. A beat is held until it is taken; after that the next
    // beat from the backlog goes out unless this cycle is picked as idle.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_taken)
        begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                next_cmd = cmd_backlog.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.cmd     <= next_cmd.cmd;
                in_ch.x_start <= next_cmd.x_start;
                in_ch.y_start <= next_cmd.y_start;
                in_ch.x_end   <= next_cmd.x_end;
                in_ch.y_end   <= next_cmd.y_end;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Pixel sink: ready is redrawn every cycle from the current stall rate.
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

    // Monitor. Pixels are checked before the command beat of the same edge is
    // predicted, since a pixel always comes out of a register after its cause.
    always @(posedge clk)
    begin : monitor
        pixel_t    want;
        pixel_t    got;
        line_cmd_t seen;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                pixels_out++;
                got = '{x: out_ch.pixel_x, y: out_ch.pixel_y,
                        rgb: out_ch.pixel_rgb, last: out_ch.last_pixel};
                if (pixel_expect_q.size() == 0)
                begin
                    $error("pixel beat (%0d,%0d) arrived with none expected", got.x, got.y);
                    fail_count++;
                end
                else
                begin
                    want = pixel_expect_q.pop_front();
                    if (got.x !== want.x)
                    begin
                        $error("pixel_x mismatch: expected %0d, got %0d", want.x, got.x);
                        fail_count++;
                    end
                    if (got.y !== want.y)
                    begin
                        $error("pixel_y mismatch: expected %0d, got %0d", want.y, got.y);
                        fail_count++;
                    end
                    if (got.rgb !== want.rgb)
                    begin
                        $error("pixel_rgb mismatch: expected %h, got %h", want.rgb, got.rgb);
                        fail_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last_pixel mismatch: expected %0d, got %0d",
                               want.last, got.last);
                        fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                beats_in++;
                seen = '{cmd: in_ch.cmd, x_start: in_ch.x_start, y_start: in_ch.y_start,
                         x_end: in_ch.x_end, y_end: in_ch.y_end};
                if (seen.cmd == CMD_START)
                    starts_in++;
                if (walk_one(seen, want))
                    pixel_expect_q.push_back(want);
            end
        end
        in_taken <= rst_n && in_ch.valid && in_ch.ready;
    end

    // Writes the color register through the APB port, then reads it back.
    // Only called while nothing is in flight, so the mirror can follow at once.
    task automatic write_color(input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PIXEL_COLOR, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        color_reg = value[RGB_BITS-1:0];
        colors_used++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[RGB_BITS-1:0] !== color_reg)
        begin
            $error("pixel_color readback mismatch: expected %h, got %h",
                   color_reg, prdata[RGB_BITS-1:0]);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Waits until every queued beat has been taken and every pixel has come
    // back, then holds on for a further wait, so that any pixel wrongly made
    // from a dropped step still arrives and is flagged.
    task automatic drain();
        @(posedge clk);
        while (cmd_backlog.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (pixel_expect_q.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic queue_cmd(input logic c, input int xs, input int ys,
                             input int xe, input int ye);
        cmd_backlog.push_back('{cmd: c, x_start: CW'(xs), y_start: CW'(ys),
                                x_end: CW'(xe), y_end: CW'(ye)});
    endtask

    // Step beats carry random coordinates, which the block must ignore.
    task automatic queue_steps(input int n);
        repeat (n)
            queue_cmd(CMD_STEP, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Picks an end coordinate d away from base, in a random direction that fits.
    function automatic int offset_coord(input int base, input int d);
        if ($urandom_range(1) && base + d <= int'(COORD_MAX))
            return base + d;
        else if (base >= d)
            return base - d;
        else
            return base + d;
    endfunction

    // Queues one random line: a start and mostly exactly enough steps to reach
    // the end. Some lines are cut short and restarted by the next start, some
    // get extra steps that land after the end and must be dropped.
    task automatic queue_random_line(input int max_span);
        int xs;
        int ys;
        int dx;
        int dy;
        int major;
        int mode;
        xs = $urandom_range(int'(COORD_MAX));
        ys = $urandom_range(int'(COORD_MAX));
        dx = $urandom_range(max_span);
        dy = $urandom_range(max_span);
        // Straight runs and single points now and then.
        mode = $urandom_range(9);
        if (mode == 0)
            dx = 0;
        else if (mode == 1)
            dy = 0;
        else if (mode == 2 && $urandom_range(1))
        begin
            dx = 0;
            dy = 0;
        end
        major = (dx > dy) ? dx : dy;
        queue_cmd(CMD_START, xs, ys, offset_coord(xs, dx), offset_coord(ys, dy));
        mode = $urandom_range(9);
        if (mode == 0 && major > 1)
        begin
            major = $urandom_range(major - 1);
            queue_steps(major);
        end
        else if (mode == 1)
        begin
            queue_steps(major);
            queue_steps($urandom_range(3, 1));
        end
        else
            queue_steps(major);
        useful_beats += major + 1;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.cmd     = CMD_START;
        in_ch.x_start = '0;
        in_ch.y_start = '0;
        in_ch.x_end   = '0;
        in_ch.y_end   = '0;
        out_ch.ready  = 1'b0;
        in_taken      = 1'b0;
        fail_count    = 0;
        beats_in      = 0;
        starts_in     = 0;
        pixels_out    = 0;
        colors_used   = 0;
        useful_beats  = 0;
        src_idle_pct  = 0;
        sink_stall_pct = 0;
        walk_col = '0;
        walk_row = '0;
        goal_col = '0;
        goal_row = '0;
        span_x   = '0;
        span_y   = '0;
        walk_err = 0;
        col_down = 1'b0;
        row_down = 1'b0;
        steep    = 1'b0;
        walking  = 1'b0;
        color_reg = '0;

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, no idling on either side. The color is still at its
        // reset value for the first beats.
        queue_steps(1);                                  // step with no line: dropped
        queue_cmd(CMD_START, 0, 0, 0, 0);                // equal endpoints at the origin
        queue_steps(1);                                  // nothing left to walk
        queue_cmd(CMD_START, 0, 0, 2047, 2047);          // full diagonal, ties go x-major
        queue_steps(2);
        queue_cmd(CMD_START, 2047, 0, 0, 2047);          // restart while busy
        queue_steps(2);
        queue_cmd(CMD_START, 5, 9, 1, 9);                // horizontal run, leftward
        queue_steps(4);
        queue_cmd(CMD_START, 100, 3, 100, 5);            // vertical run
        queue_steps(2);
        queue_cmd(CMD_START, 10, 10, 12, 14);            // steep line
        queue_steps(4);
        drain();
        write_color(32'h0000_FFFF);
        // A line left half walked across a color change: later pixels get the
        // new color. The drain here is also a full pause of the sender.
        queue_cmd(CMD_START, 2000, 40, 2006, 38);
        queue_steps(3);
        drain();
        write_color(32'h0000_F81F);
        queue_steps(4);                                  // last one falls after the end
        drain();

        // Random phases: free flow, idle sender, stalling sink, then both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 55; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 55; end
                default: begin src_idle_pct = 15; sink_stall_pct = 15; end
            endcase
            case (phase)
                0: write_color(32'h0000_0000);
                1: write_color(32'hFFFF_FFFF);           // upper bits must be ignored
                default: write_color($urandom);
            endcase
            useful_beats = 0;
            while (useful_beats < 50)
                queue_random_line(($urandom_range(7) == 0) ? 40 : 12);
            // Sender holds back until every pixel so far has come home.
            drain();
            if (phase == 3)
                queue_random_line(100);                  // one long line in the mix
            while (useful_beats < 100)
                queue_random_line(($urandom_range(7) == 0) ? 40 : 12);
            drain();
        end

        $display("Ran %0d command beats (%0d line starts) and checked %0d pixel beats,",
                 beats_in, starts_in, pixels_out);
        $display("over %0d color settings and four idle/stall mixes.", colors_used);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
